FILE: rtl/core/kstc_pkg.sv
// Shared types and codes for the keyed slot table compacting unit.
package kstc_pkg;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_GET    = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_DUPLICATE = 3'd3,
		STAT_NULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} fsm_state_t;

endpackage

FILE: rtl/core/kstc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kstc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/keyed_slot_table_compacting_unit.sv
// Top level of the keyed slot table: command sequencer around one entry RAM.
// One request on the input channel (mode, key, value) yields exactly one result on the
// output channel (status, found_value, entry_count), in order. Both channels use
// valid/ready; a request is taken when in_valid and in_ready are high at a rising edge
// of clk, a result likewise with out_valid/out_ready.
//
// The table lives in a single RAM holding {key, value} per slot, kept contiguous in
// insertion order. Get, remove and add walk the slots below the entry count one read
// per cycle (read data shows in the cycle after the read). Remove then pulls every
// later slot down by one, one slot per cycle, writing each in the cycle after its read.
//
// Clear, null add and full add go from idle straight to the done state; get, remove and
// other adds pass through the search state, which reads the slots until a hit or the
// entry count, and a remove that hits then passes through the shift state. The done
// state loads the output register. One request is in flight at a time; in_ready is high
// only while the sequencer is idle.
//
// Reset (arst_n low) empties the table; only the count is cleared. A stalled receiver
// holds the result in the output register; the next request is still taken and worked
// on, and its result waits until the output register frees.
module keyed_slot_table_compacting_unit #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_BITS    = 8,
	parameter int VALUE_BITS  = 32,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
	localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  kstc_pkg::mode_t         mode,
	input  logic [KEY_BITS-1:0]     key,
	input  logic [VALUE_BITS-1:0]   value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output kstc_pkg::status_t       status,
	output logic [VALUE_BITS-1:0]   found_value,
	output logic [CNT_W-1:0]        entry_count
);

	import kstc_pkg::*;

	localparam int ENT_W = KEY_BITS + VALUE_BITS;

	fsm_state_t state_q, state_d;

	// Request being worked on
	mode_t                 mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// Table occupancy and walk pointer (next slot to read)
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      scan_q;

	// Read in flight: slot index whose data shows on the RAM output
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;

	// Result waiting for the output register
	status_t               pend_status_q;
	logic [VALUE_BITS-1:0] pend_value_q;

	// Output register
	logic                  out_valid_q;
	status_t               status_q;
	logic [VALUE_BITS-1:0] found_value_q;
	logic [CNT_W-1:0]      entry_count_q;

	// RAM ports
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ENT_W-1:0]      ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ENT_W-1:0]      ram_rdata;

	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  hit;
	logic                  more;
	logic                  full;
	logic                  out_free;
	logic                  accept;

	assign rd_key   = ram_rdata[ENT_W-1 -: KEY_BITS];
	assign rd_val   = ram_rdata[VALUE_BITS-1:0];
	assign hit      = cmp_vld_s1 && (rd_key == key_q);
	assign more     = scan_q < count_q;
	assign full     = count_q >= CNT_W'(TABLE_DEPTH);
	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	kstc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = {key_q, value_q};
		ram_re    = 1'b0;
		ram_raddr = scan_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == MODE_CLEAR ||
					    (mode == MODE_ADD && (value == '0 || full))) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = (mode_q == MODE_REMOVE) ? ST_SHIFT : ST_DONE;
				end else if (more) begin
					ram_re = 1'b1;
				end else begin
					// Miss: an add appends at the end of the table
					ram_we  = (mode_q == MODE_ADD);
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				// Write each slot one position lower, in the cycle after its read
				ram_re    = more;
				ram_we    = cmp_vld_s1;
				ram_waddr = cmp_idx_s1 - IDX_W'(1);
				ram_wdata = ram_rdata;
				if (!more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					scan_q     <= '0;
					cmp_vld_s1 <= 1'b0;
					if (accept && mode == MODE_CLEAR) begin
						count_q <= '0;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						// Remove: start pulling from the slot after the hit
						scan_q     <= CNT_W'(cmp_idx_s1) + CNT_W'(1);
						cmp_vld_s1 <= 1'b0;
					end else if (more) begin
						scan_q     <= scan_q + CNT_W'(1);
						cmp_vld_s1 <= 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
						if (mode_q == MODE_ADD) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					if (more) begin
						scan_q     <= scan_q + CNT_W'(1);
						cmp_vld_s1 <= 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
						count_q    <= count_q - CNT_W'(1);
					end
				end
				default: begin
					cmp_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Request and pending result payload
	always_ff @(posedge clk) begin
		if (more && (state_q == ST_SEARCH || state_q == ST_SHIFT) && !hit) begin
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q        <= mode;
					key_q         <= key;
					value_q       <= value;
					pend_value_q  <= '0;
					pend_status_q <= STAT_OK;
					if (mode == MODE_ADD) begin
						if (value == '0) begin
							pend_status_q <= STAT_NULL;
						end else if (full) begin
							pend_status_q <= STAT_FULL;
						end
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					if (mode_q == MODE_ADD) begin
						pend_status_q <= STAT_DUPLICATE;
					end else if (mode_q == MODE_GET) begin
						pend_value_q <= rd_val;
					end
				end else if (!more) begin
					if (mode_q != MODE_ADD) begin
						pend_status_q <= STAT_NOT_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load when the slot is free, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			status_q      <= pend_status_q;
			found_value_q <= pend_value_q;
			entry_count_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign entry_count = entry_count_q;

endmodule

FILE: rtl/core/kstc_checker.sv
// Port-level assertions for the keyed slot table, bound to the top level.
module kstc_checker #(
	parameter int TABLE_DEPTH = 16,
	parameter int VALUE_BITS  = 32,
	parameter int CNT_W       = 5
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input kstc_pkg::status_t     status,
	input logic [VALUE_BITS-1:0] found_value,
	input logic [CNT_W-1:0]      entry_count
);

	import kstc_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(found_value) && $stable(entry_count))
		else $error("stalled result changed");

	// One request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	a_value_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_value != '0 |-> status == STAT_OK)
		else $error("nonzero value with failing status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> entry_count == CNT_W'(TABLE_DEPTH))
		else $error("full status with table not full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

endmodule

bind keyed_slot_table_compacting_unit kstc_checker #(
	.TABLE_DEPTH (TABLE_DEPTH),
	.VALUE_BITS  (VALUE_BITS),
	.CNT_W       (CNT_W)
) u_kstc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found_value (found_value),
	.entry_count (entry_count)
);

FILE: verif/keyed_slot_table_compacting_unit_test.sv
// Testbench for the keyed slot table compacting unit: directed and random commands, scoreboarded.
`timescale 1ns / 1ps

import kstc_pkg::*;

// Track the table contents and queue up the reply that each accepted request must produce.
class table_reply_scoreboard;
	localparam int DEPTH = 16;

	typedef struct {
		status_t     status;
		logic [31:0] found;
		logic [4:0]  count;
	} reply_t;

	logic [7:0]  slot_key[DEPTH];
	logic [31:0] slot_value[DEPTH];
	int          held;
	reply_t      awaited_replies[$];
	int          failures;
	int          mode_seen[4];
	int          status_seen[5];

	function new();
		held = 0;
		failures = 0;
		foreach (mode_seen[i]) mode_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	// First valid slot holding k, or -1.
	function int find_key(logic [7:0] k);
		for (int i = 0; i < held; i++) begin
			if (slot_key[i] == k) return i;
		end
		return -1;
	endfunction

	function void note_request(mode_t m, logic [7:0] k, logic [31:0] v);
		reply_t r;
		int idx;
		r.status = STAT_OK;
		r.found = '0;
		idx = find_key(k);
		case (m)
			MODE_CLEAR: begin
				held = 0;
			end
			MODE_ADD: begin
				// null check wins over full, full wins over duplicate
				if (v == '0) begin
					r.status = STAT_NULL;
				end else if (held >= DEPTH) begin
					r.status = STAT_FULL;
				end else if (idx >= 0) begin
					r.status = STAT_DUPLICATE;
				end else begin
					slot_key[held] = k;
					slot_value[held] = v;
					held++;
				end
			end
			MODE_GET: begin
				if (idx < 0) r.status = STAT_NOT_FOUND;
				else r.found = slot_value[idx];
			end
			default: begin
				if (idx < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					for (int i = idx; i + 1 < held; i++) begin
						slot_key[i] = slot_key[i + 1];
						slot_value[i] = slot_value[i + 1];
					end
					held--;
				end
			end
		endcase
		r.count = held[4:0];
		awaited_replies.push_back(r);
		mode_seen[m]++;
		status_seen[r.status]++;
	endfunction

	function void check_reply(status_t s, logic [31:0] f, logic [4:0] c);
		reply_t e;
		if (awaited_replies.size() == 0) begin
			$error("reply with no request outstanding: status %0d found_value %h entry_count %0d",
				s, f, c);
			failures++;
			return;
		end
		e = awaited_replies.pop_front();
		if (s !== e.status) begin
			$error("status: expected %0d, actual %0d", e.status, s);
			failures++;
		end
		if (f !== e.found) begin
			$error("found_value: expected %h, actual %h", e.found, f);
			failures++;
		end
		if (c !== e.count) begin
			$error("entry_count: expected %0d, actual %0d", e.count, c);
			failures++;
		end
	endfunction
endclass

module keyed_slot_table_compacting_unit_test;
	// Bound the run well above the slowest legal pacing: ~800 requests, each with a walk of
	// the table plus long sender gaps and receiver stalls.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 188;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	mode_t       mode = MODE_CLEAR;
	logic [7:0]  key = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	status_t     status;
	logic [31:0] found_value;
	logic [4:0]  entry_count;

	// Pacing per phase: no idling, sender idle, receiver stalling, both.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int snd_pct[4] = '{0, 73, 0, 18};
	int rcv_pct[4] = '{0, 0, 73, 18};
	int cycle_count = 0;

	table_reply_scoreboard sb = new();

	keyed_slot_table_compacting_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found_value(found_value),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: check each reply taken at this edge, then pick the next ready level.
	// Values read right after the edge are the ones the block saw at it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_reply(status, found_value, entry_count);
		end
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Present one request and hold it until the block takes it. Drop valid only for a gap;
	// back-to-back requests keep valid high and just swap the payload.
	task automatic send_request(mode_t m, logic [7:0] k, logic [31:0] v);
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_request(m, k, v);
	endtask

	initial begin
		mode_t       m;
		logic [7:0]  k;
		logic [31:0] v;
		logic [7:0]  key_base;
		int          roll;

		// Hold reset low, then release it on a rising edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table misses, null add, key and value extremes, duplicate,
		// hits and misses, fill to capacity, add precedence at full, removes at the
		// middle, end and front, then clear and reuse.
		send_request(MODE_CLEAR, 8'h00, 32'h0000_0000);
		send_request(MODE_GET, 8'h42, 32'hFFFF_FFFF);
		send_request(MODE_REMOVE, 8'h42, 32'h0000_0000);
		send_request(MODE_ADD, 8'h09, 32'h0000_0000);
		send_request(MODE_ADD, 8'h00, 32'h0000_0001);
		send_request(MODE_ADD, 8'hFF, 32'hFFFF_FFFF);
		send_request(MODE_ADD, 8'h00, 32'h0000_0005);
		send_request(MODE_GET, 8'hFF, 32'h0000_0000);
		send_request(MODE_GET, 8'h00, 32'hFFFF_FFFF);
		send_request(MODE_GET, 8'h03, 32'h0000_0000);
		for (int i = 0; i < 14; i++) begin
			send_request(MODE_ADD, 8'h10 + 8'(i), $urandom | 32'h1);
		end
		send_request(MODE_ADD, 8'h77, 32'h0000_0000);
		send_request(MODE_ADD, 8'h00, 32'h0000_0003);
		send_request(MODE_ADD, 8'h77, 32'h0000_0003);
		send_request(MODE_REMOVE, 8'h14, 32'h0000_0000);
		send_request(MODE_REMOVE, 8'h1D, 32'h0000_0000);
		send_request(MODE_REMOVE, 8'h00, 32'h0000_0000);
		send_request(MODE_GET, 8'h15, 32'h0000_0000);
		send_request(MODE_CLEAR, 8'hFF, 32'hFFFF_FFFF);
		send_request(MODE_GET, 8'hFF, 32'h0000_0000);
		send_request(MODE_ADD, 8'hFF, 32'h8000_0000);

		// Random: keys mostly from a narrow window so adds collide, gets and removes hit,
		// and the table regularly fills; a few keys span the whole range. Clears are rare
		// so the table gets deep between them.
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = snd_pct[phase];
			receiver_stall_pct = rcv_pct[phase];
			key_base = 8'($urandom);
			repeat (RANDOM_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) m = MODE_CLEAR;
				else if (roll < 45) m = MODE_ADD;
				else if (roll < 72) m = MODE_GET;
				else m = MODE_REMOVE;
				if ($urandom_range(0, 9) == 0) k = 8'($urandom);
				else k = key_base + 8'($urandom_range(0, 23));
				roll = $urandom_range(0, 19);
				if (roll == 0) v = '0;
				else if (roll == 1) v = '1;
				else v = $urandom;
				send_request(m, k, v);
			end
		end

		// Drain: wait out every reply, then give the block time to show a stray one.
		in_valid <= 1'b0;
		while (sb.awaited_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d clears, %0d adds, %0d gets, %0d removes across four pacing phases.",
			sb.mode_seen[MODE_CLEAR], sb.mode_seen[MODE_ADD], sb.mode_seen[MODE_GET],
			sb.mode_seen[MODE_REMOVE]);
		$display("Replies: ok %0d, not found %0d, full %0d, duplicate %0d, null refused %0d.",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_NOT_FOUND], sb.status_seen[STAT_FULL],
			sb.status_seen[STAT_DUPLICATE], sb.status_seen[STAT_NULL]);
		if (sb.failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
